### hw/rtl/vlc_pkg.sv
// Package for the vector length clamp: the request and result payload types.
// No dependencies; vector_length_clamp and the testbench use it by scoped names.
package vlc_pkg;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        [31:0] length;
    logic               was_clamped;
  } out_t;

  localparam int unsigned DataWidth = 32;

endpackage

### hw/rtl/vector_length_clamp.sv
// Vector length clamp: scales a vector down to max_length when its length exceeds that limit.
// Throughput is one request per cycle; the whole pipeline advances together and
// holds when the result register is full and not taken, so a stall loses nothing.
// The square root and the divider each take one register stage per result bit.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets max_length to 1.0.
module vector_length_clamp #(
  parameter int COMPONENT_WIDTH = 32,
  parameter int FRAC_BITS       = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vlc_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output vlc_pkg::out_t   out_data_o
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DS = (F > 0) ? F : 1;
  localparam int SW = 3 * W + 3;
  localparam int DW = vlc_pkg::DataWidth;

  logic [DW-1:0] max_length_q;
  logic          en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= DW'(1) << F;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_data_i;
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: sign and magnitude of each component.
  logic [W-1:0] raw [3];
  logic         v1_q, v2_q, v3_q;
  logic [W-1:0] mag1_q [3];
  logic [2:0]   neg1_q, neg2_q, neg3_q;
  logic [W-1:0] mag2_q [3];
  logic [W-1:0] mag3_q [3];
  logic [2*W-1:0] sq2_q [3];
  logic [2*W-1:0] sum3_q;

  assign raw[0] = in_data_i.in_x[W-1:0];
  assign raw[1] = in_data_i.in_y[W-1:0];
  assign raw[2] = in_data_i.in_z[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= raw[i][W-1];
        mag1_q[i] <= raw[i][W-1] ? W'(~raw[i] + W'(1)) : raw[i];
        sq2_q[i]  <= (2*W)'(mag1_q[i] * mag1_q[i]);
        mag2_q[i] <= mag1_q[i];
        mag3_q[i] <= mag2_q[i];
      end
      neg2_q <= neg1_q;
      neg3_q <= neg2_q;
      // The sum of three squares of W-bit magnitudes stays below 2^(2W).
      sum3_q <= sq2_q[0] + sq2_q[1] + sq2_q[2];
    end
  end

  // Square root pipeline.
  logic          sv;
  logic [W-1:0]  len;
  logic [SW-1:0] sside;

  vlc_sqrt #(.W(W), .SW(SW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (sum3_q),
    .side_i  ({neg3_q, mag3_q[0], mag3_q[1], mag3_q[2]}),
    .valid_o (sv),
    .root_o  (len),
    .side_o  (sside)
  );

  // Compare stage: decide the clamp and seed the divider.
  logic          v4_q;
  logic [W-1:0]  len4_q;
  logic [W-1:0]  num4_q;
  logic          clamp4_q;
  logic [SW-1:0] side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      len4_q   <= len;
      num4_q   <= max_length_q[W-1:0];
      clamp4_q <= DW'(len) > max_length_q;
      side4_q  <= sside;
    end
  end

  logic                dv;
  logic [DS-1:0]       quot;
  logic [SW+W:0]       dside;

  vlc_div #(.W(W), .DS(DS), .SW(SW + W + 1)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (num4_q),
    .den_i   (len4_q),
    .side_i  ({clamp4_q, len4_q, side4_q}),
    .valid_o (dv),
    .quot_o  (quot),
    .side_o  (dside)
  );

  // The divider yields max * 2^DS / len; the scale is that over 2^(DS-F).
  logic [DS-1:0] scale;
  logic [W-1:0]  dmag [3];
  logic [2:0]    dneg;
  logic          dclamp;
  logic [W-1:0]  dlen;

  assign scale   = quot >> (DS - F);
  assign dclamp  = dside[SW+W];
  assign dlen    = dside[SW+W-1:SW];
  assign dneg    = dside[SW-1:3*W];
  assign dmag[0] = dside[3*W-1:2*W];
  assign dmag[1] = dside[2*W-1:W];
  assign dmag[2] = dside[W-1:0];

  // Multiply stage.
  logic            v5_q;
  logic [W+DS-1:0] prod5_q [3];
  logic [W-1:0]    mag5_q  [3];
  logic [2:0]      neg5_q;
  logic            clamp5_q;
  logic [W-1:0]    len5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod5_q[i] <= (W+DS)'(dmag[i] * scale);
        mag5_q[i]  <= dmag[i];
      end
      neg5_q   <= dneg;
      clamp5_q <= dclamp;
      len5_q   <= dlen;
    end
  end

  // Result register: pick the scaled or original magnitude and restore the sign.
  logic [W-1:0]  m [3];
  logic [DW-1:0] res [3];
  logic          v6_q;
  vlc_pkg::out_t out6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[i]   = clamp5_q ? prod5_q[i][F +: W] : mag5_q[i];
      res[i] = neg5_q[i] ? DW'(DW'(0) - DW'(m[i])) : DW'(m[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out6_q.out_x       <= res[0];
      out6_q.out_y       <= res[1];
      out6_q.out_z       <= res[2];
      out6_q.length      <= DW'(len5_q);
      out6_q.was_clamped <= clamp5_q;
    end
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = out6_q;

  // A clamped result always has a nonzero length, since the limit is unsigned.
  a_clamp_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.was_clamped |-> out_data_o.length != 0)
    else $error("clamped result with zero length");

  // The pipeline takes a request exactly when the result register can move.
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow the result register");

  // A result that is not clamped never reports a length above the limit.
  a_noclamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.was_clamped |-> out_data_o.length <= max_length_q)
    else $error("unclamped result exceeds the limit");

endmodule

### hw/rtl/vlc_sqrt.sv
// Pipelined integer square root: one result bit per register stage.
// Self-contained; carries an opaque side vector alongside each request.
module vlc_sqrt #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [2*W-1:0] rad_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [W-1:0]   root_o,
  output logic [SW-1:0]  side_o
);

  logic           v_q    [W];
  logic [2*W-1:0] rad_q  [W];
  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [SW-1:0]  side_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic           v_p;
    logic [2*W-1:0] rad_p;
    logic [W+1:0]   rem_p;
    logic [W-1:0]   root_p;
    logic [SW-1:0]  side_p;
    logic [W+2:0]   r2;
    logic [W+2:0]   trial;

    if (k == 0) begin : g_first
      assign v_p    = valid_i;
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
    end

    // Bring down the next two radicand bits and try the digit one.
    assign r2    = {rem_p[W:0], rad_p[2*W-1:2*W-2]};
    assign trial = {1'b0, root_p, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_p << 2;
        side_q[k] <= side_p;
        if (r2 >= trial) begin
          rem_q[k]  <= (W+2)'(r2 - trial);
          root_q[k] <= {root_p[W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= (W+2)'(r2);
          root_q[k] <= {root_p[W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[W-1];
  assign root_o  = root_q[W-1];
  assign side_o  = side_q[W-1];

endmodule

### hw/rtl/vlc_div.sv
// Pipelined restoring divider: DS quotient bits of num * 2^DS / den, one per stage.
// Self-contained; num must be below den for the quotient to be meaningful.
module vlc_div #(
  parameter int W  = 32,
  parameter int DS = 16,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DS-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [DS];
  logic [W-1:0]  rem_q  [DS];
  logic [W-1:0]  den_q  [DS];
  logic [DS-1:0] quot_q [DS];
  logic [SW-1:0] side_q [DS];

  for (genvar k = 0; k < DS; k++) begin : g_stage
    logic          v_p;
    logic [W-1:0]  rem_p;
    logic [W-1:0]  den_p;
    logic [DS-1:0] quot_p;
    logic [SW-1:0] side_p;
    logic [W:0]    r2;

    if (k == 0) begin : g_first
      assign v_p    = valid_i;
      assign rem_p  = num_i;
      assign den_p  = den_i;
      assign quot_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign den_p  = den_q[k-1];
      assign quot_p = quot_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign r2 = {rem_p, 1'b0};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
        if (r2 >= {1'b0, den_p}) begin
          rem_q[k]  <= W'(r2 - {1'b0, den_p});
          quot_q[k] <= {quot_p[DS-1:0] << 1} | DS'(1);
        end else begin
          rem_q[k]  <= W'(r2);
          quot_q[k] <= quot_p << 1;
        end
      end
    end
  end

  assign valid_o = v_q[DS-1];
  assign quot_o  = quot_q[DS-1];
  assign side_o  = side_q[DS-1];

endmodule

### dv/testbench.sv
// Testbench for vector_length_clamp: directed vectors from a table, then random ones,
// each result checked field by field against the table or a behavioural length-clamp predictor.
// Depends on vlc_pkg and the vector_length_clamp RTL only.
`timescale 1ns / 100ps

module testbench;

  localparam int FRAC = 16;
  localparam int LATENCY = 54;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    vlc_pkg::in_t  vec;
    bit            known;
    vlc_pkg::out_t res;
  } row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [31:0]   cfg_data_i;
  logic          in_valid_i;
  logic          in_ready_o;
  vlc_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  vlc_pkg::out_t out_data_o;

  vlc_pkg::out_t pending_results[$];
  int     error_count;
  longint cycle_count;
  logic [31:0] limit_reg;
  bit     calm;
  row_t   rows[$];

  vector_length_clamp dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic vlc_pkg::out_t clamp_vector(vlc_pkg::in_t v, logic [31:0] limit);
    logic [31:0]   comp[3];
    logic [63:0]   mag[3];
    bit            neg[3];
    logic [63:0]   sum;
    logic [63:0]   len;
    logic [63:0]   scale;
    logic [31:0]   res[3];
    vlc_pkg::out_t r;
    comp[0] = v.in_x;
    comp[1] = v.in_y;
    comp[2] = v.in_z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][31];
      mag[i] = neg[i] ? (64'd1 << 32) - {32'd0, comp[i]} : {32'd0, comp[i]};
      sum += mag[i] * mag[i];
    end
    len = floor_sqrt(sum);
    r.was_clamped = len > {32'd0, limit};
    if (r.was_clamped) begin
      scale = ({32'd0, limit} << FRAC) / len;
      for (int i = 0; i < 3; i++) mag[i] = (mag[i] * scale) >> FRAC;
    end
    for (int i = 0; i < 3; i++) res[i] = neg[i] ? -mag[i][31:0] : mag[i][31:0];
    r.out_x = res[0];
    r.out_y = res[1];
    r.out_z = res[2];
    r.length = len[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic tick();
    @(posedge clk_i);
  endtask

  // Result side: random back-pressure in bursts, none once calm is set.
  initial begin
    int hold;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 9);
        out_ready_i <= 1'b0;
        repeat (hold) tick();
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) tick();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("MISMATCH unexpected result (cycle %0d)", cycle_count);
        error_count++;
      end else begin
        vlc_pkg::out_t want;
        want = pending_results.pop_front();
        if (out_data_o.out_x !== want.out_x) report_mismatch("out_x", out_data_o.out_x, want.out_x);
        if (out_data_o.out_y !== want.out_y) report_mismatch("out_y", out_data_o.out_y, want.out_y);
        if (out_data_o.out_z !== want.out_z) report_mismatch("out_z", out_data_o.out_z, want.out_z);
        if (out_data_o.length !== want.length)
          report_mismatch("length", out_data_o.length, want.length);
        if (out_data_o.was_clamped !== want.was_clamped)
          report_mismatch("was_clamped", {31'd0, out_data_o.was_clamped}, {31'd0, want.was_clamped});
      end
    end
  end

  // Holds valid until accepted; the next request follows on without a dip in valid unless a random gap comes first.
  task automatic send_request(vlc_pkg::in_t v, bit known, vlc_pkg::out_t res);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) tick();
    end
    in_valid_i <= 1'b1;
    in_data_i <= v;
    pending_results.push_back(known ? res : clamp_vector(v, limit_reg));
    do tick(); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) tick();
    repeat (4) tick();
  endtask

  task automatic write_limit(logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    tick();
    cfg_we_i <= 1'b0;
    limit_reg = value;
  endtask

  function automatic logic [31:0] random_component(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 262144)) - 131072;
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit known,
                         logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [31:0] len, bit clamped);
    row_t r;
    r.vec = '{in_x: x, in_y: y, in_z: z};
    r.known = known;
    r.res = '{out_x: ox, out_y: oy, out_z: oz, length: len, was_clamped: clamped};
    rows.push_back(r);
  endtask

  initial begin
    logic [31:0]  limits[6];
    int           mode;
    vlc_pkg::in_t v;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    error_count = 0;
    cycle_count = 0;
    calm = 1'b0;
    limit_reg = 32'h0001_0000;
    repeat (3) tick();
    rst_ni <= 1'b1;
    tick();

    // Directed rows under the reset limit of 1.0.
    add_row(0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(32'h0000_8000, 0, 0, 1, 32'h0000_8000, 0, 0, 32'h0000_8000, 0);
    add_row(32'h0001_0000, 0, 0, 1, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
    add_row(32'h0002_0000, 0, 0, 1, 32'h0001_0000, 0, 0, 32'h0002_0000, 1);
    add_row(0, 32'hfffe_0000, 0, 1, 0, 32'hffff_0000, 0, 32'h0002_0000, 1);
    add_row(32'h8000_0000, 0, 0, 1, 32'hffff_0000, 0, 0, 32'h8000_0000, 1);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 0, 0, 0, 0, 0, 0);
    add_row(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 0, 0, 0, 0, 0, 0);
    foreach (rows[i]) send_request(rows[i].vec, rows[i].known, rows[i].res);
    drain();

    // Zero limit: every nonzero vector collapses to zero.
    write_limit(32'd0);
    send_request('{in_x: 32'h0001_0000, in_y: 0, in_z: 0}, 1,
                 '{out_x: 0, out_y: 0, out_z: 0, length: 32'h0001_0000, was_clamped: 1});
    send_request('{in_x: 0, in_y: 0, in_z: 0}, 1,
                 '{out_x: 0, out_y: 0, out_z: 0, length: 0, was_clamped: 0});
    send_request('{in_x: 32'h8000_0000, in_y: 32'h7fff_ffff, in_z: 1}, 0, '0);
    drain();
    // Largest limit: nothing is ever clamped.
    write_limit(32'hffff_ffff);
    send_request('{in_x: 32'h8000_0000, in_y: 32'h8000_0000, in_z: 32'h8000_0000}, 0, '0);
    send_request('{in_x: 32'h7fff_ffff, in_y: 32'h8000_0001, in_z: 32'h1234_5678}, 0, '0);
    drain();

    limits = '{32'd0, 32'h0001_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0010_0000, 32'h8000_0000};
    for (int phase = 0; phase < 6; phase++) begin
      write_limit(phase == 5 ? $urandom() : limits[phase]);
      if (phase == 5) calm = 1'b1;
      for (int n = 0; n < 300; n++) begin
        mode = $urandom_range(0, 9);
        v.in_x = random_component(mode % 4);
        v.in_y = random_component($urandom_range(0, 3));
        v.in_z = random_component(mode < 8 ? mode % 4 : 1);
        send_request(v, 0, '0);
      end
      // The sender waits here for every outstanding result before the next limit.
      drain();
    end
    repeat (LATENCY + 10) tick();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/vlc_pkg.sv
hw/rtl/vlc_sqrt.sv
hw/rtl/vlc_div.sv
hw/rtl/vector_length_clamp.sv
dv/testbench.sv
